FILE: hw/rtl/ptsb_pkg.sv
// Package: shared types and constants of the periodic timer slot bank
`default_nettype none
package ptsb_pkg;
   localparam int SLOTS = 16;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W = 5;

   typedef enum logic [2:0] {
      OP_TICK = 3'd0, OP_ADD = 3'd1, OP_SET_RATE = 3'd2, OP_REMOVE = 3'd3,
      OP_RESUME = 3'd4, OP_STOP = 3'd5, OP_SERVICE = 3'd6, OP_CLEAR = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_NO_FREE = 3'd2,
      ST_NOT_CONFIG = 3'd3, ST_BAD_ARG = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DIV, S_SERV, S_SERV_WAIT, S_RESP
   } state_type;

   // divider control and status
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_sts_type;
endpackage
`default_nettype wire

FILE: hw/rtl/ptsb_divider.sv
// Restoring serial divider: 32-bit dividend over a 16-bit divisor, low 16 quotient bits out
`default_nettype none
module ptsb_divider (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ptsb_pkg::div_ctl_type ctl,
   input  wire logic [31:0]           dividend,
   input  wire logic [15:0]           divisor,
   output ptsb_pkg::div_sts_type      sts
);
   import ptsb_pkg::*;

   logic [31:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [16:0] shifted;
   logic [16:0] diff;

   // one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[15:0], quo_ff[31]};
      diff    = shifted - {1'b0, dsr_ff};
      if (ctl.start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dsr_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign sts.done     = busy_ff && (cnt_ff == 6'd1);
   assign sts.quotient = quo_in[15:0];
endmodule
`default_nettype wire

FILE: hw/rtl/periodic_timer_slot_bank_core.sv
// Top level: bank of periodic timer slots with a serial slot scan and divider
//
// Usage: one request word (opcode, client_id, rate) is taken on the req_
// channel when req_valid is high and req_stall low. Each request gives one
// response word on the rsp_ channel, except service, which gives one word per
// fired slot (rsp_last marks the final one), or a single empty word.
// Requests are handled one at a time; req_stall is high while busy and until
// the final response word is taken, so the next request is taken in the cycle after.
// Clear goes straight to its response; a request rejected on its arguments or
// on a missing base_frequency is answered without a slot walk; tick and a
// lookup that ends without the divider walk the slots one per cycle; add and
// set_rate then run the 32-step serial divider.
// Service walks the slots one per cycle while the response is not stalled and
// sends a word for each fired slot; the empty word comes after the walk.
// A stalled response is held unchanged until taken; the slot walk waits.
// The csr_ port writes base_frequency; write only while idle.
// Reset (synchronous) frees all slots and clears base_frequency and the
// error flag; the block is ready in the next cycle.
`default_nettype none
module periodic_timer_slot_bank_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_client_id,
   input  wire logic [15:0] req_rate,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic             rsp_fire_valid,
   output logic [15:0]      rsp_fired_id,
   output logic             rsp_last,
   output logic [4:0]       rsp_active_count,
   output logic             rsp_error_flag
);
   import ptsb_pkg::*;

   // slot state: flip-flops with reset values
   logic [15:0] key_ff [SLOTS];
   logic [15:0] cnt_ff [SLOTS];
   logic [15:0] rld_ff [SLOTS];
   logic [SLOTS-1:0] run_ff, fired_ff;
   logic [CNT_W-1:0] alloc_ff;
   logic err_ff;
   logic [31:0] base_ff;

   state_type state_ff, state_in;
   opcode_type op_ff;
   logic [15:0] id_ff, rate_ff;
   logic [SLOT_W:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic [SLOT_W:0] nserv_ff, nserv_in;
   logic [SLOT_W-1:0] sidx;
   logic [SLOTS-1:0] upper_fired;

   // response register
   logic rv_ff;
   status_type rst_ff;
   logic rfv_ff, rlast_ff;
   logic [15:0] rid_ff;
   logic [CNT_W-1:0] rcnt_ff;
   logic rerr_ff;

   div_ctl_type dctl;
   div_sts_type dsts;

   logic accept, rsp_take, rsp_free;
   logic scan_end;
   logic [15:0] dec;
   logic emit, emit_last, emit_fv;
   status_type emit_st;
   logic [15:0] emit_id;
   logic precheck_done;
   status_type pre_st;

   assign accept   = req_valid && !req_stall;
   assign rsp_take = rv_ff && !rsp_stall;
   assign rsp_free = !rv_ff || !rsp_stall;
   assign sidx     = idx_ff[SLOT_W-1:0];
   assign scan_end = (idx_ff == (SLOT_W+1)'(SLOTS - 1));
   assign dec      = cnt_ff[sidx] - 16'd1;
   // fired slots above the one under the walk
   assign upper_fired = fired_ff & ({SLOTS{1'b1}} << (idx_ff + 1'b1));

   ptsb_divider u_div (
      .clock(clock), .reset(reset), .ctl(dctl),
      .dividend(base_ff), .divisor(rate_ff), .sts(dsts)
   );

   // early rejection of management requests
   always_comb begin
      precheck_done = 1'b1;
      pre_st = ST_OK;
      if (base_ff == 32'd0) pre_st = ST_NOT_CONFIG;
      else if (id_ff == 16'd0 ||
               ((op_ff == OP_ADD || op_ff == OP_SET_RATE) && rate_ff == 16'd0))
         pre_st = ST_BAD_ARG;
      else precheck_done = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            if (req_opcode == OP_SERVICE) state_in = S_SERV;
            else if (req_opcode == OP_CLEAR) state_in = S_RESP;
            else state_in = S_SCAN;
         end
         S_SCAN: begin
            if (op_ff != OP_TICK && precheck_done) state_in = S_RESP;
            else if (scan_end) begin
               if ((op_ff == OP_ADD || op_ff == OP_SET_RATE) &&
                   (found_ff || (op_ff == OP_ADD ? key_ff[sidx] == 16'd0
                                                 : key_ff[sidx] == id_ff)))
                  state_in = S_DIV;
               else state_in = S_RESP;
            end
         end
         S_DIV:  if (dsts.done) state_in = S_RESP;
         S_SERV: if (rsp_free) begin
            if (idx_ff == (SLOT_W+1)'(SLOTS)) state_in = S_SERV_WAIT;
            else if (fired_ff[sidx] && scan_end) state_in = S_SERV_WAIT;
         end
         S_SERV_WAIT: if (rsp_free) state_in = S_IDLE;
         S_RESP: if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and scan control
   always_comb begin
      idx_in = idx_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      nserv_in = nserv_ff;
      dctl.start = 1'b0;
      emit = 1'b0;
      emit_last = 1'b1;
      emit_fv = 1'b0;
      emit_id = 16'd0;
      emit_st = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            found_in = 1'b0;
            nserv_in = '0;
         end
         S_SCAN: begin
            if (!found_ff && ((op_ff == OP_ADD && key_ff[sidx] == 16'd0) ||
                (op_ff != OP_ADD && key_ff[sidx] == id_ff))) begin
               found_in = 1'b1;
               hit_in = sidx;
            end
            idx_in = idx_ff + 1'b1;
            if (state_in == S_DIV) dctl.start = 1'b1;
         end
         S_SERV: if (rsp_free && idx_ff != (SLOT_W+1)'(SLOTS)) begin
            idx_in = idx_ff + 1'b1;
            if (fired_ff[sidx]) begin
               emit = 1'b1;
               emit_fv = 1'b1;
               emit_id = key_ff[sidx];
               emit_last = (upper_fired == '0);
               nserv_in = nserv_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   // slot state, base register and request capture
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         base_ff <= '0;
         run_ff <= '0;
         fired_ff <= '0;
         alloc_ff <= '0;
         err_ff <= 1'b0;
         idx_ff <= '0;
         found_ff <= 1'b0;
         nserv_ff <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i] <= '0;
            cnt_ff[i] <= '0;
            rld_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         hit_ff <= hit_in;
         found_ff <= found_in;
         nserv_ff <= nserv_in;
         if (csr_wr_en) base_ff <= csr_wr_data;
         if (accept) begin
            op_ff <= opcode_type'(req_opcode);
            id_ff <= req_client_id;
            rate_ff <= req_rate;
            if (req_opcode == OP_CLEAR) begin
               run_ff <= '0;
               fired_ff <= '0;
               alloc_ff <= '0;
               err_ff <= 1'b0;
               for (int i = 0; i < SLOTS; i++) begin
                  key_ff[i] <= '0;
                  cnt_ff[i] <= '0;
                  rld_ff[i] <= '0;
               end
            end
         end
         // tick one slot per cycle
         if (state_ff == S_SCAN && op_ff == OP_TICK && run_ff[sidx]) begin
            if (dec == 16'd0) begin
               cnt_ff[sidx] <= rld_ff[sidx];
               fired_ff[sidx] <= 1'b1;
            end else cnt_ff[sidx] <= dec;
         end
         if (state_ff == S_SERV && emit) fired_ff[sidx] <= 1'b0;
         // finish management ops at the end of the slot scan, before the response is produced
         if (state_ff == S_SCAN && op_ff != OP_TICK && !precheck_done &&
             scan_end && state_in == S_RESP) begin
            if (op_ff == OP_ADD) err_ff <= 1'b1;
            else if (found_in) begin
               unique case (op_ff)
                  OP_REMOVE: begin
                     key_ff[hit_in] <= '0;
                     cnt_ff[hit_in] <= '0;
                     rld_ff[hit_in] <= '0;
                     run_ff[hit_in] <= 1'b0;
                     fired_ff[hit_in] <= 1'b0;
                     if (alloc_ff != '0) alloc_ff <= alloc_ff - 1'b1;
                  end
                  OP_RESUME: run_ff[hit_in] <= 1'b1;
                  OP_STOP: begin
                     run_ff[hit_in] <= 1'b0;
                     fired_ff[hit_in] <= 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         if (state_ff == S_DIV && dsts.done) begin
            rld_ff[hit_ff] <= dsts.quotient;
            cnt_ff[hit_ff] <= dsts.quotient;
            if (op_ff == OP_ADD) begin
               key_ff[hit_ff] <= id_ff;
               run_ff[hit_ff] <= 1'b1;
               fired_ff[hit_ff] <= 1'b0;
               if (alloc_ff != 5'd31) alloc_ff <= alloc_ff + 1'b1;
            end
         end
      end
   end

   // result status of a single-word response
   status_type fin_st_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) fin_st_ff <= ST_OK;
      else if (state_ff == S_SCAN && op_ff != OP_TICK) begin
         if (precheck_done) fin_st_ff <= pre_st;
         else if (scan_end && !found_in)
            fin_st_ff <= (op_ff == OP_ADD) ? ST_NO_FREE : ST_NOT_FOUND;
      end
   end

   // response register; counts read after the state update lands
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         if (emit) begin
            rv_ff <= 1'b1;
            rst_ff <= emit_st;
            rfv_ff <= emit_fv;
            rid_ff <= emit_id;
            rlast_ff <= emit_last;
            rcnt_ff <= alloc_ff;
            rerr_ff <= err_ff;
         end else if (state_ff == S_RESP && rsp_free) begin
            rv_ff <= 1'b1;
            rst_ff <= fin_st_ff;
            rfv_ff <= 1'b0;
            rid_ff <= '0;
            rlast_ff <= 1'b1;
            rcnt_ff <= alloc_ff;
            rerr_ff <= err_ff;
         end else if (state_ff == S_SERV_WAIT && rsp_free && nserv_ff == '0) begin
            // nothing fired: send the single empty word
            rv_ff <= 1'b1;
            rst_ff <= ST_OK;
            rfv_ff <= 1'b0;
            rid_ff <= '0;
            rlast_ff <= 1'b1;
            rcnt_ff <= alloc_ff;
            rerr_ff <= err_ff;
         end else if (rsp_take) begin
            rv_ff <= 1'b0;
         end
      end
   end

   assign req_stall        = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid        = rv_ff;
   assign rsp_status       = rst_ff;
   assign rsp_fire_valid   = rfv_ff;
   assign rsp_fired_id     = rid_ff;
   assign rsp_last         = rlast_ff;
   assign rsp_active_count = rcnt_ff;
   assign rsp_error_flag   = rerr_ff;
endmodule
`default_nettype wire

FILE: tb/sv/ptsb_checker.sv
// Checker: predicts the timer slot bank's response words and compares them
`timescale 1ns / 1ps
`default_nettype none
module ptsb_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [15:0] req_client_id,
   input  wire logic [15:0] req_rate,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic        rsp_fire_valid,
   input  wire logic [15:0] rsp_fired_id,
   input  wire logic        rsp_last,
   input  wire logic [4:0]  rsp_active_count,
   input  wire logic        rsp_error_flag,
   output int               fail_count,
   output int               pending_words,
   output int               fire_words
);
   import ptsb_pkg::*;

   typedef struct packed {
      logic [2:0]  status;
      logic        fire_valid;
      logic [15:0] fired_id;
      logic        last;
      logic [4:0]  active_count;
      logic        error_flag;
   } timer_word_type;

   timer_word_type expected_words[$];

   logic [31:0] tick_hz;
   logic [15:0] key_q[SLOTS];
   logic [15:0] count_q[SLOTS];
   logic [15:0] reload_q[SLOTS];
   logic        run_q[SLOTS];
   logic        fired_q[SLOTS];
   int unsigned used_slots;
   logic        full_q;

   assign pending_words = expected_words.size();

   function automatic timer_word_type make_word(logic [2:0] st, logic fv,
                                                logic [15:0] id, logic lst);
      timer_word_type w;
      w.status = st;
      w.fire_valid = fv;
      w.fired_id = id;
      w.last = lst;
      w.active_count = (used_slots > 31) ? 5'd31 : used_slots[4:0];
      w.error_flag = full_q;
      return w;
   endfunction

   task automatic wipe_bank();
      for (int i = 0; i < SLOTS; i++) begin
         key_q[i] = '0; count_q[i] = '0; reload_q[i] = '0;
         run_q[i] = 1'b0; fired_q[i] = 1'b0;
      end
      used_slots = 0;
      full_q = 1'b0;
   endtask

   // Work out the words one request produces and advance the bank copy
   task automatic predict_request(opcode_type op, logic [15:0] id, logic [15:0] rt);
      status_type  st;
      int          hit;
      int          n;
      logic [31:0] quot;
      st = ST_OK;
      hit = -1;
      n = 0;
      quot = '0;
      if (op == OP_TICK) begin
         for (int i = 0; i < SLOTS; i++)
            if (run_q[i]) begin
               count_q[i] = count_q[i] - 16'd1;
               if (count_q[i] == 16'd0) begin
                  count_q[i] = reload_q[i];
                  fired_q[i] = 1'b1;
               end
            end
      end else if (op == OP_SERVICE) begin
         for (int i = 0; i < SLOTS; i++)
            if (fired_q[i]) begin
               fired_q[i] = 1'b0;
               expected_words.push_back(make_word(ST_OK, 1'b1, key_q[i], 1'b0));
               n++;
            end
         if (n == 0)
            expected_words.push_back(make_word(ST_OK, 1'b0, 16'd0, 1'b1));
         else
            expected_words[$].last = 1'b1;
         return;
      end else if (op == OP_CLEAR) begin
         wipe_bank();
      end else if (tick_hz == 0) begin
         st = ST_NOT_CONFIG;
      end else if (id == 0 || ((op == OP_ADD || op == OP_SET_RATE) && rt == 0)) begin
         st = ST_BAD_ARG;
      end else begin
         for (int i = SLOTS - 1; i >= 0; i--)
            if (key_q[i] == ((op == OP_ADD) ? 16'd0 : id)) hit = i;
         if (rt != 0) quot = tick_hz / rt;
         if (hit < 0) begin
            if (op == OP_ADD) begin
               full_q = 1'b1;
               st = ST_NO_FREE;
            end else st = ST_NOT_FOUND;
         end else begin
            case (op)
               OP_ADD: begin
                  key_q[hit] = id; run_q[hit] = 1'b1; fired_q[hit] = 1'b0;
                  reload_q[hit] = quot[15:0]; count_q[hit] = quot[15:0];
                  used_slots++;
               end
               OP_SET_RATE: begin
                  reload_q[hit] = quot[15:0]; count_q[hit] = quot[15:0];
               end
               OP_REMOVE: begin
                  key_q[hit] = '0; count_q[hit] = '0; reload_q[hit] = '0;
                  run_q[hit] = 1'b0; fired_q[hit] = 1'b0;
                  if (used_slots > 0) used_slots--;
               end
               OP_RESUME: run_q[hit] = 1'b1;
               default: begin
                  run_q[hit] = 1'b0; fired_q[hit] = 1'b0;
               end
            endcase
         end
      end
      expected_words.push_back(make_word(st, 1'b0, 16'd0, 1'b1));
   endtask

   // Track config, predict on each accepted request, compare each response word
   always @(posedge clock) begin
      timer_word_type exp_w;
      int errs;
      errs = 0;
      if (reset) begin
         tick_hz = '0;
         wipe_bank();
         expected_words.delete();
         fail_count <= 0;
         fire_words <= 0;
      end else begin
         if (csr_wr_en) tick_hz = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("response word with nothing expected");
               errs++;
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_fire_valid) fire_words <= fire_words + 1;
               if (rsp_status !== exp_w.status) begin
                  $error("status: expected %0d, got %0d", exp_w.status, rsp_status);
                  errs++;
               end
               if (rsp_fire_valid !== exp_w.fire_valid) begin
                  $error("fire_valid: expected %0d, got %0d",
                         exp_w.fire_valid, rsp_fire_valid);
                  errs++;
               end
               if (rsp_fired_id !== exp_w.fired_id) begin
                  $error("fired_id: expected %0d, got %0d", exp_w.fired_id, rsp_fired_id);
                  errs++;
               end
               if (rsp_last !== exp_w.last) begin
                  $error("last: expected %0d, got %0d", exp_w.last, rsp_last);
                  errs++;
               end
               if (rsp_active_count !== exp_w.active_count) begin
                  $error("active_count: expected %0d, got %0d",
                         exp_w.active_count, rsp_active_count);
                  errs++;
               end
               if (rsp_error_flag !== exp_w.error_flag) begin
                  $error("error_flag: expected %0d, got %0d",
                         exp_w.error_flag, rsp_error_flag);
                  errs++;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
         // requests are predicted after any word leaving in the same cycle
         if (req_valid && !req_stall)
            predict_request(opcode_type'(req_opcode), req_client_id, req_rate);
      end
   end
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Testbench top: drives requests and config writes into the timer slot bank
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import ptsb_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_opcode = '0;
   logic [15:0] req_client_id = '0;
   logic [15:0] req_rate = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic        rsp_fire_valid;
   logic [15:0] rsp_fired_id;
   logic        rsp_last;
   logic [4:0]  rsp_active_count;
   logic        rsp_error_flag;
   int          fail_count;
   int          pending_words;
   int          fire_words;
   int          idle_cycles = 0;
   int          requests_sent = 0;
   logic        hold_off = 1'b0;
   logic        steady_rx = 1'b0;

   localparam int IDLE_LIMIT = 20000;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   periodic_timer_slot_bank_core u_dut (.*);
   ptsb_checker u_chk (.*);

   // Receiver: own stall pattern, with steady stretches and one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_off) rsp_stall <= 1'b1;
      else if (steady_rx) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Watchdog: count cycles in which no word moves on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_word(opcode_type op, logic [15:0] id, logic [15:0] rt);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_client_id <= id;
      req_rate <= rt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic gap_cycles(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Let the bank drain, then write base_frequency while idle
   task automatic write_rate_base(logic [31:0] hz);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= hz;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Random word: mostly well-formed, with management ids from a small pool
   task automatic random_word();
      int          pick;
      logic [15:0] id;
      logic [15:0] rt;
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) id = 16'd0;
      rt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4));
      if ($urandom_range(0, 15) == 0) rt = 16'd0;
      if (pick < 40) send_word(OP_TICK, 16'($urandom), 16'($urandom));
      else if (pick < 55) send_word(OP_ADD, id, rt);
      else if (pick < 65) send_word(OP_SERVICE, id, rt);
      else if (pick < 71) send_word(OP_SET_RATE, id, rt);
      else if (pick < 77) send_word(OP_REMOVE, id, rt);
      else if (pick < 84) send_word(OP_RESUME, id, rt);
      else if (pick < 90) send_word(OP_STOP, id, rt);
      else if (pick < 93) send_word(OP_CLEAR, id, rt);
      else send_word(opcode_type'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: unconfigured bank, then id and rate extremes
      send_word(OP_ADD, 16'd5, 16'd1);
      send_word(OP_SET_RATE, 16'd5, 16'd1);
      send_word(OP_REMOVE, 16'd5, 16'd0);
      send_word(OP_RESUME, 16'd5, 16'd0);
      send_word(OP_STOP, 16'd5, 16'd0);
      send_word(OP_TICK, 16'hFFFF, 16'hFFFF);
      send_word(OP_SERVICE, 16'd0, 16'd0);
      write_rate_base(32'd2);
      send_word(OP_ADD, 16'd0, 16'd1);
      send_word(OP_ADD, 16'd7, 16'd0);
      send_word(OP_REMOVE, 16'd0, 16'd1);
      send_word(OP_STOP, 16'd9, 16'd1);
      send_word(OP_ADD, 16'hFFFF, 16'd1);
      send_word(OP_ADD, 16'hFFFF, 16'd2);
      send_word(OP_ADD, 16'd3, 16'hFFFF);     // reload of zero
      send_word(OP_TICK, 16'd0, 16'd0);
      send_word(OP_TICK, 16'd0, 16'd0);
      send_word(OP_SERVICE, 16'd0, 16'd0);
      send_word(OP_SET_RATE, 16'hFFFF, 16'd2);
      send_word(OP_STOP, 16'hFFFF, 16'd0);
      send_word(OP_RESUME, 16'hFFFF, 16'd0);
      send_word(OP_REMOVE, 16'hFFFF, 16'd0);
      // fill the bank past full, tick so every slot but the zero-reload one fires, then clear
      for (int i = 0; i < 16; i++) send_word(OP_ADD, 16'(i + 100), 16'd2);
      send_word(OP_TICK, 16'd0, 16'd0);
      steady_rx <= 1'b1;
      send_word(OP_SERVICE, 16'd0, 16'd0);
      steady_rx <= 1'b0;
      send_word(OP_CLEAR, 16'd0, 16'd0);

      // Random phases over several base frequencies
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: write_rate_base(32'd3);
            1: write_rate_base(32'hFFFF_FFFF);
            2: write_rate_base(32'd0);
            default: write_rate_base($urandom_range(1, 8));
         endcase
         if (phase == 3) steady_rx <= 1'b1;
         for (int n = 0; n < 15 || (phase == 3 && fire_words < 40 && n < 30); ) begin
            int burst;
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst; b++) begin
               random_word();
               n++;
            end
            gap_cycles($urandom_range(0, 8));
         end
         steady_rx <= 1'b0;
         if (phase == 0) begin
            // long receiver hold-off while requests keep coming
            hold_off <= 1'b1;
            fork
               begin
                  repeat (400) @(posedge clock);
                  hold_off <= 1'b0;
               end
               for (int b = 0; b < 6; b++) send_word(OP_TICK, 16'd0, 16'd0);
            join
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Run covered %0d requests over four base frequencies, %0d fired words.",
               requests_sent, fire_words);
      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
hw/rtl/ptsb_pkg.sv
hw/rtl/ptsb_divider.sv
hw/rtl/periodic_timer_slot_bank_core.sv
tb/sv/ptsb_checker.sv
tb/sv/testbench.sv
